### rtl/core/lct_pkg.sv
package lct_pkg;

	// geometry
	localparam int MAX_SET_BITS = 8;
	localparam int MAX_WAYS     = 8;
	localparam int LINE_COUNT   = MAX_WAYS << MAX_SET_BITS;

	localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int SBIT_W = $clog2(MAX_SET_BITS + 1);
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int LINE_W = $clog2(LINE_COUNT);

	// field widths
	localparam int ADDR_W  = 64;
	localparam int TAG_W   = 64;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 6;
	localparam int CIDX_W  = 2;

	localparam logic [STAMP_W-1:0] CLOCK_CEILING = 32'h7FFF_FFFF;
	localparam logic [CNT_W-1:0]   COUNT_CEILING = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_WAYS_IN_USE       = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

	typedef struct packed {
		logic             init;
		logic             vld;
		logic [WAY_W-1:0] way;
	} scan_ctrl_t;

	typedef struct packed {
		logic               hit;
		logic [STAMP_W-1:0] best;
		logic [WAY_W-1:0]   victim;
	} scan_stat_t;

	function automatic logic [LINE_W-1:0] line_index(
		input logic [SET_W-1:0] set_idx,
		input logic [WAY_W-1:0] way
	);
		return LINE_W'(set_idx) * LINE_W'(MAX_WAYS) + LINE_W'(way);
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(
		input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] ceiling
	);
		return (v < ceiling) ? v + CNT_W'(1) : ceiling;
	endfunction

endpackage

### rtl/core/lct_ram.sv
module lct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/lct_addr_split.sv
module lct_addr_split
	import lct_pkg::*;
(
	input  logic              clk,
	input  logic              load,
	input  logic [ADDR_W-1:0] address,
	input  logic [5:0]        block_offset_bits,
	input  logic [3:0]        set_index_bits,
	output logic [SET_W-1:0]  set_idx_s2,
	output logic [TAG_W-1:0]  tag_s2
);

	logic [ADDR_W-1:0] block_s1;
	logic [SBIT_W-1:0] sbits_eff;
	logic [SET_W-1:0]  set_mask;

	// oversized set index counts act as the maximum
	assign sbits_eff = (32'(set_index_bits) > MAX_SET_BITS) ?
		SBIT_W'(MAX_SET_BITS) : SBIT_W'(set_index_bits);
	assign set_mask  = ~({SET_W{1'b1}} << sbits_eff);

	// stage 1: drop the block offset
	always_ff @(posedge clk) begin
		if (load) begin
			block_s1 <= address >> block_offset_bits;
		end
	end

	// stage 2: split into set index and tag
	always_ff @(posedge clk) begin
		set_idx_s2 <= block_s1[SET_W-1:0] & set_mask;
		tag_s2     <= block_s1 >> sbits_eff;
	end

endmodule

### rtl/core/lct_way_cmp.sv
module lct_way_cmp
	import lct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  scan_ctrl_t         ctrl,
	input  logic [STAMP_W-1:0] stamp_rd,
	input  logic [TAG_W-1:0]   tag_rd,
	input  logic [TAG_W-1:0]   tag_key,
	output logic               match,
	output scan_stat_t         stat
);

	logic               hit_q;
	logic [STAMP_W-1:0] best_q;
	logic [WAY_W-1:0]   victim_q;

	// a line takes part only while its stamp is nonzero
	assign match = ctrl.vld && (stamp_rd != '0) && (tag_rd == tag_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.init) begin
			hit_q <= 1'b0;
		end else if (match) begin
			hit_q <= 1'b1;
		end
	end

	// running minimum, strict compare keeps the lowest way on ties
	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			best_q   <= COUNT_CEILING;
			victim_q <= '0;
		end else if (ctrl.vld && (stamp_rd < best_q)) begin
			best_q   <= stamp_rd;
			victim_q <= ctrl.way;
		end
	end

	assign stat.hit    = hit_q;
	assign stat.best   = best_q;
	assign stat.victim = victim_q;

endmodule

### rtl/core/lru_cache_tag_simulator.sv
// set-associative cache tag model with least-recently-used replacement.
// each input beat is a 64-bit byte address: block_offset_bits low bits are
// dropped, the next set_index_bits bits pick a set (up to 256 sets) and the
// remaining upper bits form the full 64-bit tag. the first ways_in_use lines
// of the set (up to 8) are walked one way per cycle through the single read
// port of the tag and stamp memories; a line is valid when its stamp is
// nonzero. a hit refreshes every matching line, a miss fills the line with
// the smallest stamp (lowest way on ties) and flags an eviction if it was
// valid. each input gives one output beat with hit, eviction and saturating
// hit, miss and eviction totals.
// an accepted address passes the shift, split, scan, update and finish states
// in order; the next address is taken only after its result has moved to the
// output register, and the way walk over the memory read port sets the pace.
// after reset a clearing pass zeroes all 2048 stamps, one per cycle, and no
// address is taken until it ends; configuration writes are taken at any time
// but must only change while the block is idle.
module lru_cache_tag_simulator
	import lct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ADDR_W-1:0] address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic              eviction,
	output logic [CNT_W-1:0]  hit_total,
	output logic [CNT_W-1:0]  miss_total,
	output logic [CNT_W-1:0]  eviction_total
);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_SHIFT  = 7'b0000100,
		ST_SPLIT  = 7'b0001000,
		ST_SCAN   = 7'b0010000,
		ST_UPDATE = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [3:0] set_index_bits_q;
	logic [3:0] ways_in_use_q;
	logic [5:0] block_offset_bits_q;
	logic [WCNT_W-1:0] ways_eff;

	// sequencer and bookkeeping
	logic [LINE_W-1:0]  clr_idx_q;
	logic [WCNT_W-1:0]  rd_way_q;
	logic               cmp_vld_s1;
	logic [WAY_W-1:0]   cmp_way_s1;
	logic [STAMP_W-1:0] clock_q;
	logic [CNT_W-1:0]   hit_cnt_q;
	logic [CNT_W-1:0]   miss_cnt_q;
	logic [CNT_W-1:0]   evict_cnt_q;
	logic               hit_res_q;
	logic               evict_res_q;

	// output register
	logic               out_valid_q;
	logic               hit_out_q;
	logic               evict_out_q;
	logic [CNT_W-1:0]   hit_total_q;
	logic [CNT_W-1:0]   miss_total_q;
	logic [CNT_W-1:0]   evict_total_q;

	// datapath
	logic [SET_W-1:0]   set_idx;
	logic [TAG_W-1:0]   tag_key;
	logic               rd_en;
	logic [LINE_W-1:0]  rd_addr;
	logic [STAMP_W-1:0] stamp_rd;
	logic [TAG_W-1:0]   tag_rd;
	logic               stamp_we;
	logic [LINE_W-1:0]  stamp_waddr;
	logic [STAMP_W-1:0] stamp_wdata;
	logic               tag_we;
	logic               cmp_match;
	scan_ctrl_t         scan_ctrl;
	scan_stat_t         scan_stat;
	logic               in_take;
	logic               out_take;
	logic               out_load;
	logic               miss_evict;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	// result can move to the output register once the previous one is gone
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	// way count clamped to 1..MAX_WAYS
	always_comb begin
		if (ways_in_use_q == '0) begin
			ways_eff = WCNT_W'(1);
		end else if (32'(ways_in_use_q) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_in_use_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_index_bits_q    <= '0;
			ways_in_use_q       <= 4'd1;
			block_offset_bits_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_INDEX_BITS: begin
					set_index_bits_q <= cfg_data[3:0];
				end
				CFG_WAYS_IN_USE: begin
					ways_in_use_q <= cfg_data[3:0];
				end
				CFG_BLOCK_OFFSET_BITS: begin
					block_offset_bits_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	lct_addr_split u_split (
		.clk               (clk),
		.load              (in_take),
		.address           (address),
		.block_offset_bits (block_offset_bits_q),
		.set_index_bits    (set_index_bits_q),
		.set_idx_s2        (set_idx),
		.tag_s2            (tag_key)
	);

	// one way read per cycle while walking the set
	assign rd_en   = (state_q == ST_SCAN) && (rd_way_q < ways_eff);
	assign rd_addr = line_index(set_idx, rd_way_q[WAY_W-1:0]);

	assign scan_ctrl.init = (state_q == ST_SPLIT);
	assign scan_ctrl.vld  = cmp_vld_s1;
	assign scan_ctrl.way  = cmp_way_s1;

	lct_way_cmp u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (scan_ctrl),
		.stamp_rd (stamp_rd),
		.tag_rd   (tag_rd),
		.tag_key  (tag_key),
		.match    (cmp_match),
		.stat     (scan_stat)
	);

	// stamp write port: clearing pass, hit refresh, miss fill
	always_comb begin
		stamp_we    = 1'b0;
		stamp_waddr = line_index(set_idx, cmp_way_s1);
		stamp_wdata = clock_q;
		case (state_q)
			ST_CLEAR: begin
				stamp_we    = 1'b1;
				stamp_waddr = clr_idx_q;
				stamp_wdata = '0;
			end
			ST_SCAN: begin
				stamp_we = cmp_match;
			end
			ST_UPDATE: begin
				stamp_we    = !scan_stat.hit;
				stamp_waddr = line_index(set_idx, scan_stat.victim);
			end
			default: begin
			end
		endcase
	end

	assign tag_we     = (state_q == ST_UPDATE) && !scan_stat.hit;
	assign miss_evict = (scan_stat.best != '0);

	lct_ram #(
		.WIDTH (STAMP_W),
		.DEPTH (LINE_COUNT)
	) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (stamp_waddr),
		.wdata (stamp_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (stamp_rd)
	);

	lct_ram #(
		.WIDTH (TAG_W),
		.DEPTH (LINE_COUNT)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (line_index(set_idx, scan_stat.victim)),
		.wdata (tag_key),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (tag_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			rd_way_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_way_s1  <= '0;
			clock_q     <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			hit_res_q   <= 1'b0;
			evict_res_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			cmp_way_s1 <= rd_way_q[WAY_W-1:0];
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + LINE_W'(1);
					if (clr_idx_q == LINE_W'(LINE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					// access clock stops at the ceiling so stamps never wrap to zero
					clock_q  <= sat_inc(clock_q, CLOCK_CEILING);
					rd_way_q <= '0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_way_q <= rd_way_q + WCNT_W'(1);
					end
					// last way is being compared this cycle
					if (!rd_en && cmp_vld_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					hit_res_q   <= scan_stat.hit;
					evict_res_q <= !scan_stat.hit && miss_evict;
					if (scan_stat.hit) begin
						hit_cnt_q <= sat_inc(hit_cnt_q, COUNT_CEILING);
					end else begin
						miss_cnt_q <= sat_inc(miss_cnt_q, COUNT_CEILING);
						if (miss_evict) begin
							evict_cnt_q <= sat_inc(evict_cnt_q, COUNT_CEILING);
						end
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_out_q     <= hit_res_q;
			evict_out_q   <= evict_res_q;
			hit_total_q   <= hit_cnt_q;
			miss_total_q  <= miss_cnt_q;
			evict_total_q <= evict_cnt_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_out_q;
	assign eviction       = evict_out_q;
	assign hit_total      = hit_total_q;
	assign miss_total     = miss_total_q;
	assign eviction_total = evict_total_q;

	// hit and eviction are exclusive on every result
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && eviction))
		else $error("hit and eviction both set");

	// only the clearing pass may write a zero stamp
	a_stamp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(stamp_we && (state_q != ST_CLEAR)) |-> (stamp_wdata != '0))
		else $error("zero stamp written outside clearing pass");

	// at least one way was compared before the update
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (scan_stat.best <= CLOCK_CEILING))
		else $error("update reached without a compared way");

	// the way walk never runs past the configured way count
	a_way_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_way_q <= ways_eff))
		else $error("way counter beyond way count");

endmodule

### dv/lru_cache_tag_simulator_test.sv
`timescale 1ns / 100ps

module lru_cache_tag_simulator_test;
	import lct_pkg::*;

	// run shape
	localparam int          NUM_SEGMENTS  = 12;          // random segments, four per idling phase
	localparam int          SEG_LOOKUPS   = 33;          // lookups per random segment
	localparam int          TAG_POOL_SIZE = MAX_WAYS + 2;
	localparam int          SETTLE_CYCLES = 2 * MAX_WAYS + 8;
	localparam int unsigned TIMEOUT_NS    = 2_000_000;   // clearing pass plus every beat, many times over

	typedef struct packed {
		logic             hit;
		logic             eviction;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] eviction_total;
	} lookup_result_t;

	// a directed row may carry its answer typed in; otherwise the predictor decides
	typedef struct packed {
		logic           typed;
		lookup_result_t want;
	} answer_t;

	typedef enum logic {
		ROW_LOOKUP,
		ROW_REG_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [CIDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]  reg_val;
		logic [ADDR_W-1:0] addr;
		logic              typed;
		lookup_result_t    want;
	} stim_row_t;

	localparam lookup_result_t NO_ANSWER = '0;
	localparam int N_DIRECTED = 27;

	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// reset registers: one set, one way, tag is the whole address
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0000_0000, 1'b1,
			'{1'b0, 1'b0, 32'd0, 32'd1, 32'd0}},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0000_0000, 1'b1,
			'{1'b1, 1'b0, 32'd1, 32'd1, 32'd0}},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{1'b0, 1'b1, 32'd1, 32'd2, 32'd1}},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{1'b1, 1'b0, 32'd2, 32'd2, 32'd1}},
		// the new tag shares only its top bit with the line held
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h8000_0000_0000_0000, 1'b1,
			'{1'b0, 1'b1, 32'd2, 32'd3, 32'd2}},
		// set bits above the maximum, two ways, 64-byte blocks
		'{ROW_REG_WRITE, CFG_SET_INDEX_BITS,    6'd15, 64'h0, 1'b0, NO_ANSWER},
		'{ROW_REG_WRITE, CFG_WAYS_IN_USE,       6'd2,  64'h0, 1'b0, NO_ANSWER},
		'{ROW_REG_WRITE, CFG_BLOCK_OFFSET_BITS, 6'd6,  64'h0, 1'b0, NO_ANSWER},
		// lru order inside set 5
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0000_0140, 1'b0, NO_ANSWER},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0001_0140, 1'b0, NO_ANSWER},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0000_0140, 1'b0, NO_ANSWER},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0002_0140, 1'b0, NO_ANSWER},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0001_0140, 1'b0, NO_ANSWER},
		// largest offset, zero ways acts as one
		'{ROW_REG_WRITE, CFG_BLOCK_OFFSET_BITS, 6'd63, 64'h0, 1'b0, NO_ANSWER},
		'{ROW_REG_WRITE, CFG_SET_INDEX_BITS,    6'd0,  64'h0, 1'b0, NO_ANSWER},
		'{ROW_REG_WRITE, CFG_WAYS_IN_USE,       6'd0,  64'h0, 1'b0, NO_ANSWER},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h8000_0000_0000_0001, 1'b0, NO_ANSWER},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_ANSWER},
		// build the same tag in both ways of set 0, then hit them together
		'{ROW_REG_WRITE, CFG_BLOCK_OFFSET_BITS, 6'd0, 64'h0, 1'b0, NO_ANSWER},
		'{ROW_REG_WRITE, CFG_WAYS_IN_USE,       6'd2, 64'h0, 1'b0, NO_ANSWER},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0000_0007, 1'b0, NO_ANSWER},
		'{ROW_REG_WRITE, CFG_WAYS_IN_USE,       6'd1, 64'h0, 1'b0, NO_ANSWER},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0000_0007, 1'b0, NO_ANSWER},
		'{ROW_REG_WRITE, CFG_WAYS_IN_USE,       6'd2, 64'h0, 1'b0, NO_ANSWER},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0000_0007, 1'b0, NO_ANSWER},
		// equal stamps now, so the victim is the lowest way
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0000_0009, 1'b0, NO_ANSWER},
		'{ROW_LOOKUP, CFG_SET_INDEX_BITS, 6'd0, 64'h0000_0000_0000_0007, 1'b0, NO_ANSWER}
	};

	// dut signals; the inputs are all known from time zero
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [ADDR_W-1:0] address   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              hit;
	logic              eviction;
	logic [CNT_W-1:0]  hit_total;
	logic [CNT_W-1:0]  miss_total;
	logic [CNT_W-1:0]  eviction_total;

	// predictor copy of the cache
	logic [TAG_W-1:0]   tag_mem   [LINE_COUNT];
	logic [STAMP_W-1:0] stamp_mem [LINE_COUNT];
	logic [STAMP_W-1:0] access_stamp;
	logic [CNT_W-1:0]   hits_seen;
	logic [CNT_W-1:0]   misses_seen;
	logic [CNT_W-1:0]   evictions_seen;
	logic [3:0]         reg_set_bits;
	logic [3:0]         reg_ways;
	logic [5:0]         reg_offset;

	logic [TAG_W-1:0] tag_pool [TAG_POOL_SIZE];

	lookup_result_t pending_lookups [$];
	answer_t        typed_answers   [$];

	int unsigned send_idle_pct = 23;
	int unsigned recv_idle_pct = 57;
	int unsigned mismatches    = 0;

	lru_cache_tag_simulator u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.address        (address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.eviction       (eviction),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// one lookup of the predictor: updates stamps, tags and totals
	function automatic lookup_result_t lru_lookup(input logic [ADDR_W-1:0] addr);
		int unsigned        sbits;
		int unsigned        ways;
		int unsigned        set_no;
		int unsigned        line;
		int unsigned        victim;
		logic [STAMP_W-1:0] best;
		logic [ADDR_W-1:0]  blk;
		logic [TAG_W-1:0]   tag;
		lookup_result_t     r;
		sbits = (reg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : reg_set_bits;
		ways  = (reg_ways == 0) ? 1 : ((reg_ways > MAX_WAYS) ? MAX_WAYS : reg_ways);
		blk    = addr >> reg_offset;
		set_no = int'(blk & ((ADDR_W'(1) << sbits) - 1));
		tag    = blk >> sbits;
		// stamp clock holds below the top bit so a stamp never wraps to invalid
		if (access_stamp < CLOCK_CEILING)
			access_stamp = access_stamp + 1;
		r      = '0;
		victim = set_no * MAX_WAYS;
		best   = '1;
		for (int unsigned w = 0; w < ways; w++) begin
			line = set_no * MAX_WAYS + w;
			// every valid copy of the tag is refreshed, duplicates included
			if (stamp_mem[line] != 0 && tag_mem[line] == tag) begin
				stamp_mem[line] = access_stamp;
				r.hit = 1'b1;
			end
			if (stamp_mem[line] < best) begin
				best   = stamp_mem[line];
				victim = line;
			end
		end
		if (r.hit) begin
			if (hits_seen != COUNT_CEILING)
				hits_seen = hits_seen + 1;
		end else begin
			if (misses_seen != COUNT_CEILING)
				misses_seen = misses_seen + 1;
			if (stamp_mem[victim] != 0) begin
				r.eviction = 1'b1;
				if (evictions_seen != COUNT_CEILING)
					evictions_seen = evictions_seen + 1;
			end
			tag_mem[victim]   = tag;
			stamp_mem[victim] = access_stamp;
		end
		r.hit_total      = hits_seen;
		r.miss_total     = misses_seen;
		r.eviction_total = evictions_seen;
		return r;
	endfunction

	// mostly a small working set so sets fill, hit and evict; some raw noise
	function automatic logic [ADDR_W-1:0] random_address();
		logic [ADDR_W-1:0] noise;
		logic [ADDR_W-1:0] blk;
		logic [ADDR_W-1:0] set_pick;
		int unsigned       sbits;
		int unsigned       ways;
		noise = {$urandom, $urandom};
		if ($urandom_range(99) < 15)
			return noise;
		sbits = (reg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : reg_set_bits;
		ways  = (reg_ways == 0) ? 1 : ((reg_ways > MAX_WAYS) ? MAX_WAYS : reg_ways);
		set_pick = ($urandom_range(99) < 80) ? ADDR_W'($urandom_range(1)) : ADDR_W'($urandom);
		blk = (tag_pool[$urandom_range(ways + 1)] << sbits)
			| (set_pick & ((ADDR_W'(1) << sbits) - 1));
		return (blk << reg_offset) | (noise & ((ADDR_W'(1) << reg_offset) - 1));
	endfunction

	// one beat on the address channel, with a random sender gap ahead of it
	task automatic send_address(input logic [ADDR_W-1:0] addr);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		address  <= addr;
		do @(posedge clk); while (in_stall);
	endtask

	// register write; the caller drops cfg_we after the last of a group
	task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_SET_INDEX_BITS:    reg_set_bits = val[3:0];
			CFG_WAYS_IN_USE:       reg_ways     = val[3:0];
			CFG_BLOCK_OFFSET_BITS: reg_offset   = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// stop sending, let every outstanding lookup come back, then let the pipe drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_lookups.size() != 0 || typed_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// receiver stalls at random each cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// accepted address beat: predict now, in order with the beats before it
	always @(posedge clk) begin
		lookup_result_t predicted;
		answer_t        answer;
		if (arst_n && in_valid && !in_stall) begin
			predicted = lru_lookup(address);
			answer    = typed_answers.pop_front();
			pending_lookups.push_back(answer.typed ? answer.want : predicted);
		end
	end

	// accepted result beat against the oldest outstanding lookup
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_lookups.size() == 0) begin
				$error("result beat with no lookup outstanding");
				mismatches++;
			end else begin
				want = pending_lookups.pop_front();
				check_field("hit", CNT_W'(want.hit), CNT_W'(hit));
				check_field("eviction", CNT_W'(want.eviction), CNT_W'(eviction));
				check_field("hit_total", want.hit_total, hit_total);
				check_field("miss_total", want.miss_total, miss_total);
				check_field("eviction_total", want.eviction_total, eviction_total);
			end
		end
	end

	initial begin
		logic [3:0] sb;
		logic [3:0] wy;
		logic [5:0] off;
		for (int i = 0; i < LINE_COUNT; i++) begin
			tag_mem[i]   = '0;
			stamp_mem[i] = '0;
		end
		access_stamp   = '0;
		hits_seen      = '0;
		misses_seen    = '0;
		evictions_seen = '0;
		reg_set_bits   = 4'd0;
		reg_ways       = 4'd1;
		reg_offset     = 6'd0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; the clearing pass after reset simply shows as stall
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED_ROWS[i].kind == ROW_REG_WRITE) begin
				if (i == 0 || DIRECTED_ROWS[i - 1].kind != ROW_REG_WRITE)
					wait_idle();
				write_register(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].reg_val);
				if (i + 1 == N_DIRECTED || DIRECTED_ROWS[i + 1].kind != ROW_REG_WRITE)
					cfg_we <= 1'b0;
			end else begin
				typed_answers.push_back('{DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want});
				send_address(DIRECTED_ROWS[i].addr);
			end
		end

		// random segments, each under its own register setting
		for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
			case (seg / (NUM_SEGMENTS / 3))
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 57;
				end
				1: begin
					send_idle_pct = 57;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case ($urandom_range(5))
				0:       sb = 4'd0;
				1:       sb = 4'(MAX_SET_BITS);
				2:       sb = 4'd15;
				default: sb = 4'($urandom_range(1, 4));
			endcase
			case ($urandom_range(6))
				0:       wy = 4'd0;
				1:       wy = 4'd1;
				2:       wy = 4'(MAX_WAYS);
				3:       wy = 4'd15;
				default: wy = 4'($urandom_range(2, 7));
			endcase
			case ($urandom_range(5))
				0:       off = 6'd0;
				1:       off = 6'd32;
				2:       off = 6'd63;
				default: off = 6'($urandom_range(1, 12));
			endcase
			for (int k = 0; k < TAG_POOL_SIZE; k++)
				tag_pool[k] = {$urandom, $urandom};

			wait_idle();
			write_register(CFG_SET_INDEX_BITS, CFG_W'(sb));
			write_register(CFG_WAYS_IN_USE, CFG_W'(wy));
			write_register(CFG_BLOCK_OFFSET_BITS, off);
			cfg_we <= 1'b0;

			for (int n = 0; n < SEG_LOOKUPS; n++) begin
				typed_answers.push_back('{1'b0, NO_ANSWER});
				send_address(random_address());
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hang guard
	initial begin
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### lru_cache_tag_simulator.f
rtl/core/lct_pkg.sv
rtl/core/lct_ram.sv
rtl/core/lct_addr_split.sv
rtl/core/lct_way_cmp.sv
rtl/core/lru_cache_tag_simulator.sv
dv/lru_cache_tag_simulator_test.sv
